/* rtl/sci_pkg.sv */
// Shared types, constants and saturation helpers for the spectrum channel integrator.
`default_nettype none
package sci_pkg;

  localparam int unsigned CHANNELS_DEF = 1024;
  localparam int unsigned SUM_W        = 48;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned CNT_W        = 16;
  localparam int unsigned CH_W         = 10;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned ENTRY_W      = 2 * SUM_W + CNT_W;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FLAG  = 2'd1;
  localparam logic [1:0] STAT_BLANK = 2'd2;

  localparam logic [1:0] CFG_NOFLAG = 2'd0;
  localparam logic [1:0] CFG_MINOR1 = 2'd1;
  localparam logic [1:0] CFG_MINOR2 = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

  function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] v);
    logic signed [SUM_W-1:0] r;
    if (v[SUM_W] != v[SUM_W-1]) begin
      r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = v[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [CNT_W-1:0] sat16(input logic signed [CNT_W:0] v);
    logic signed [CNT_W-1:0] r;
    if (v[CNT_W] != v[CNT_W-1]) begin
      r = v[CNT_W] ? {1'b1, {(CNT_W-1){1'b0}}} : {1'b0, {(CNT_W-1){1'b1}}};
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/sci_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sci_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* rtl/sci_div.sv */
// Bit-serial signed divider: two 48-bit numerators by one 16-bit count, saturating.
`default_nettype none
module sci_div (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire sci_pkg::div_ctl_t                      ctl_i,
  input  wire logic signed [sci_pkg::SUM_W-1:0]      num_re_i,
  input  wire logic signed [sci_pkg::SUM_W-1:0]      num_im_i,
  input  wire logic signed [sci_pkg::CNT_W-1:0]      den_i,
  output sci_pkg::div_ctl_t                           ctl_o,
  output logic signed      [sci_pkg::SUM_W-1:0]      q_re_o,
  output logic signed      [sci_pkg::SUM_W-1:0]      q_im_o
);

  localparam int unsigned SW = sci_pkg::SUM_W;
  localparam int unsigned CW = sci_pkg::CNT_W;
  localparam int unsigned KW = $clog2(SW);

  logic          run_q, done_q;
  logic [KW-1:0] cnt_q;
  logic [SW-1:0] sh_re_q, sh_im_q;
  logic [CW-1:0] rem_re_q, rem_im_q, den_q;
  logic          neg_re_q, neg_im_q;

  logic [CW:0]   tr_re, tr_im;
  logic          ge_re, ge_im;

  assign tr_re = {rem_re_q, sh_re_q[SW-1]};
  assign tr_im = {rem_im_q, sh_im_q[SW-1]};
  assign ge_re = tr_re >= {1'b0, den_q};
  assign ge_im = tr_im >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == KW'(SW - 1));
      if (ctl_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        if (cnt_q == KW'(SW - 1)) begin
          run_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      sh_re_q  <= num_re_i[SW-1] ? SW'(-num_re_i) : num_re_i;
      sh_im_q  <= num_im_i[SW-1] ? SW'(-num_im_i) : num_im_i;
      den_q    <= den_i[CW-1] ? CW'(-den_i) : den_i;
      neg_re_q <= num_re_i[SW-1] ^ den_i[CW-1];
      neg_im_q <= num_im_i[SW-1] ^ den_i[CW-1];
      rem_re_q <= '0;
      rem_im_q <= '0;
    end else if (run_q) begin
      rem_re_q <= ge_re ? CW'(tr_re - {1'b0, den_q}) : tr_re[CW-1:0];
      rem_im_q <= ge_im ? CW'(tr_im - {1'b0, den_q}) : tr_im[CW-1:0];
      sh_re_q  <= {sh_re_q[SW-2:0], ge_re};
      sh_im_q  <= {sh_im_q[SW-2:0], ge_im};
    end
  end

  // quotient magnitude is at most 2^47; only the positive side can overflow
  always_comb begin
    if (neg_re_q)         q_re_o = SW'(-sh_re_q);
    else if (sh_re_q[SW-1]) q_re_o = {1'b0, {(SW-1){1'b1}}};
    else                  q_re_o = sh_re_q;
    if (neg_im_q)         q_im_o = SW'(-sh_im_q);
    else if (sh_im_q[SW-1]) q_im_o = {1'b0, {(SW-1){1'b1}}};
    else                  q_im_o = sh_im_q;
  end

  assign ctl_o.start = run_q;
  assign ctl_o.done  = done_q;

endmodule
`default_nettype wire

/* rtl/spectrum_channel_integrator_unit.sv */
// Top level of the spectrum channel integrator: channel store, sequencer and result register.
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one transaction per channel: an
//    accumulate (req_type_i = 0) or a normalise-and-read (req_type_i = 1).
//  - Output channel (out_valid_o/out_ready_i) returns one transaction for every read
//    and for every accumulate with frame_last_i set; other accumulates return nothing.
//  - Configuration is a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i), written idle.
//  - Per-channel sums and counts live in one RAM word; each transaction reads its word
//    and writes back any change to it before the next transaction is taken, so no
//    forwarding is needed.
//  - Steps: an accumulate reads the RAM word and then updates it; with a result it
//    then loads the output register. A read that needs a division runs the bit-serial
//    divider before the load.
//  - The output register holds a finished result while the receiver stalls; the next
//    transaction is taken meanwhile and waits in the sequencer until the slot frees.
//  - Reset clears the loaded flag, reason word, minor-tracking counters and masks.
//    The store is not cleared: entries are undefined until first written.
`default_nettype none
module spectrum_channel_integrator_unit #(
  parameter int unsigned CHANNELS = sci_pkg::CHANNELS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 req_type_i,
  input  wire logic        [sci_pkg::CH_W-1:0]      channel_i,
  input  wire logic signed [sci_pkg::VAL_W-1:0]     in_real_i,
  input  wire logic signed [sci_pkg::VAL_W-1:0]     in_imag_i,
  input  wire logic signed [sci_pkg::CNT_W-1:0]     in_count_i,
  input  wire logic                                 frame_last_i,
  input  wire logic        [sci_pkg::WORD_W-1:0]    frame_reason_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic signed      [sci_pkg::SUM_W-1:0]     out_real_o,
  output logic signed      [sci_pkg::SUM_W-1:0]     out_imag_o,
  output logic signed      [sci_pkg::CNT_W-1:0]     out_count_o,
  output logic             [1:0]                    flag_status_o,
  output logic             [sci_pkg::WORD_W-1:0]    reason_word_o,
  output logic             [sci_pkg::WORD_W-1:0]    minor1_total_o,
  output logic             [sci_pkg::WORD_W-1:0]    minor2_total_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic        [1:0]                    cfg_idx_i,
  input  wire logic        [sci_pkg::WORD_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(CHANNELS);
  localparam int unsigned SW = sci_pkg::SUM_W;
  localparam int unsigned CW = sci_pkg::CNT_W;
  localparam int unsigned EW = sci_pkg::ENTRY_W;

  // transaction held while it is processed
  logic                    req_q, last_q;
  logic [sci_pkg::CH_W-1:0] ch_q;
  logic signed [sci_pkg::VAL_W-1:0] ar_q, ai_q;
  logic signed [CW-1:0]    ac_q;
  logic [sci_pkg::WORD_W-1:0] rsn_q;

  logic loaded_q, loaded_d;
  logic [sci_pkg::WORD_W-1:0] reason_q, reason_d, m1_q, m1_d, m2_q, m2_d;
  logic [sci_pkg::WORD_W-1:0] noflag_q, m1mask_q, m2mask_q;

  sci_pkg::state_e state_q, state_d;

  logic signed [SW-1:0] res_re_q, res_re_d, res_im_q, res_im_d;
  logic signed [CW-1:0] res_c_q, res_c_d;

  logic out_valid_q;
  logic accept, slot_free;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  sci_pkg::div_ctl_t div_in, div_out;
  logic signed [SW-1:0] q_re, q_im;

  logic signed [SW-1:0] st_re, st_im, nw_re, nw_im;
  logic signed [CW-1:0] st_c, nw_c;
  logic                 inr, need_div;
  logic [16:0]          ch_ext;

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;

  assign st_re = ram_rdata[EW-1 -: SW];
  assign st_im = ram_rdata[EW-SW-1 -: SW];
  assign st_c  = ram_rdata[CW-1:0];

  assign ch_ext    = 17'(ch_q);
  assign inr       = ch_ext < 17'(CHANNELS);
  assign ram_waddr = AW'(ch_ext);
  assign ram_raddr = AW'(17'(channel_i));
  assign ram_re    = accept;
  assign need_div  = inr && (st_c < 0 || st_c > 1);

  // accumulate update of the entry just read
  always_comb begin
    nw_re = st_re;
    nw_im = st_im;
    nw_c  = st_c;
    if (!loaded_q) begin
      nw_re = SW'(ar_q);
      nw_im = SW'(ai_q);
      nw_c  = ac_q;
    end else if (ac_q > 0) begin
      if (st_c > 0) begin
        nw_re = sci_pkg::sat48((SW+1)'(st_re) + (SW+1)'(ar_q));
        nw_im = sci_pkg::sat48((SW+1)'(st_im) + (SW+1)'(ai_q));
      end else begin
        nw_re = SW'(ar_q);
        nw_im = SW'(ai_q);
      end
      nw_c = sci_pkg::sat16((CW+1)'(st_c) + (CW+1)'(ac_q));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sci_pkg::ST_IDLE: if (accept) state_d = sci_pkg::ST_CALC;
      sci_pkg::ST_CALC: begin
        if (req_q) state_d = need_div ? sci_pkg::ST_DIV : sci_pkg::ST_PUSH;
        else       state_d = last_q ? sci_pkg::ST_PUSH : sci_pkg::ST_IDLE;
      end
      sci_pkg::ST_DIV:  if (div_out.done) state_d = sci_pkg::ST_PUSH;
      sci_pkg::ST_PUSH: if (slot_free) state_d = sci_pkg::ST_IDLE;
      default:          state_d = sci_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    ram_we       = 1'b0;
    ram_wdata    = {nw_re, nw_im, nw_c};
    div_in.start = 1'b0;
    div_in.done  = 1'b0;
    res_re_d     = res_re_q;
    res_im_d     = res_im_q;
    res_c_d      = res_c_q;
    loaded_d     = loaded_q;
    reason_d     = reason_q;
    m1_d         = m1_q;
    m2_d         = m2_q;
    case (state_q)
      sci_pkg::ST_IDLE: in_ready_o = 1'b1;
      sci_pkg::ST_CALC: begin
        if (req_q) begin
          div_in.start = need_div;
          res_re_d = inr ? st_re : '0;
          res_im_d = inr ? st_im : '0;
          res_c_d  = inr ? st_c : '0;
        end else begin
          ram_we   = inr;
          res_re_d = inr ? nw_re : '0;
          res_im_d = inr ? nw_im : '0;
          res_c_d  = inr ? nw_c : '0;
          if (last_q) begin
            loaded_d = 1'b1;
            reason_d = reason_q | rsn_q;
            if ((rsn_q & m1mask_q) != '0) m1_d = m1_q + 1'b1;
            if ((rsn_q & m2mask_q) != '0) m2_d = m2_q + 1'b1;
          end
        end
      end
      sci_pkg::ST_DIV: begin
        if (div_out.done) begin
          ram_we    = 1'b1;
          ram_wdata = {q_re, q_im, CW'(1)};
          res_re_d  = q_re;
          res_im_d  = q_im;
          res_c_d   = CW'(1);
        end
      end
      sci_pkg::ST_PUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sci_pkg::ST_IDLE;
      loaded_q    <= 1'b0;
      reason_q    <= '0;
      m1_q        <= '0;
      m2_q        <= '0;
      noflag_q    <= '0;
      m1mask_q    <= '0;
      m2mask_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      reason_q <= reason_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sci_pkg::CFG_NOFLAG: noflag_q <= cfg_data_i;
          sci_pkg::CFG_MINOR1: m1mask_q <= cfg_data_i;
          sci_pkg::CFG_MINOR2: m2mask_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == sci_pkg::ST_PUSH && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i)                        out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      ch_q   <= channel_i;
      ar_q   <= in_real_i;
      ai_q   <= in_imag_i;
      ac_q   <= in_count_i;
      last_q <= frame_last_i;
      rsn_q  <= frame_reason_i;
    end
    res_re_q <= res_re_d;
    res_im_q <= res_im_d;
    res_c_q  <= res_c_d;
    // status and totals are taken as they stand after the transaction
    if (state_q == sci_pkg::ST_PUSH && slot_free) begin
      out_real_o     <= res_re_q;
      out_imag_o     <= res_im_q;
      out_count_o    <= res_c_q;
      reason_word_o  <= reason_q;
      minor1_total_o <= m1_q;
      minor2_total_o <= m2_q;
      if (!loaded_q)                        flag_status_o <= sci_pkg::STAT_BLANK;
      else if ((reason_q & ~noflag_q) != '0) flag_status_o <= sci_pkg::STAT_FLAG;
      else                                  flag_status_o <= sci_pkg::STAT_OK;
    end
  end

  assign out_valid_o = out_valid_q;

  sci_ram #(
    .WIDTH (EW),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sci_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (div_in),
    .num_re_i (st_re),
    .num_im_i (st_im),
    .den_i    (st_c),
    .ctl_o    (div_out),
    .q_re_o   (q_re),
    .q_im_o   (q_im)
  );

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && state_q == sci_pkg::ST_IDLE))
    else $error("store written while idle");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_out.done |-> state_q == sci_pkg::ST_DIV)
    else $error("divider finished outside division state");

  a_out_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == sci_pkg::ST_PUSH)
    else $error("result raised without push");
`endif

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the spectrum channel integrator unit.
`default_nettype none
module testbench;
  import sci_pkg::*;

  typedef enum bit {REQ_ACC = 1'b0, REQ_READ = 1'b1} req_e;

  typedef struct {
    req_e                     kind;
    logic [CH_W-1:0]          chan;
    logic signed [VAL_W-1:0]  re;
    logic signed [VAL_W-1:0]  im;
    logic signed [CNT_W-1:0]  cnt;
    logic                     last;
    logic [WORD_W-1:0]        reason;
  } spec_txn_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  re;
    logic signed [SUM_W-1:0]  im;
    logic signed [CNT_W-1:0]  cnt;
    logic [1:0]               status;
    logic [WORD_W-1:0]        reason;
    logic [WORD_W-1:0]        m1;
    logic [WORD_W-1:0]        m2;
  } spec_res_t;

  // Integrator mirror: holds the channel store, frame state and masks, and queues the
  // result each accepted read or frame-ending accumulate should produce.
  class integ_scoreboard;
    longint      acc_re[1024];
    longint      acc_im[1024];
    int          acc_cnt[1024];
    bit          touched[1024];
    bit          loaded;
    bit [31:0]   reason_acc, m1_cnt, m2_cnt;
    bit [31:0]   noflag, m1_mask, m2_mask;
    spec_res_t   due[$];
    int          errors;

    function longint clip48(longint v);
      if (v > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (v < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return v;
    endfunction

    function int clip16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] val);
      case (idx)
        CFG_NOFLAG: noflag = val;
        CFG_MINOR1: m1_mask = val;
        CFG_MINOR2: m2_mask = val;
        default: ;
      endcase
    endfunction

    function void note(spec_txn_t t);
      int unsigned ch;
      longint      r, i, ar, ai;
      int          c, ac;
      spec_res_t   e;
      ch = t.chan;
      if (t.kind == REQ_READ) begin
        r = acc_re[ch];
        i = acc_im[ch];
        c = acc_cnt[ch];
        // counts of 0 and 1 are left alone; others normalise to count 1
        if (c < 0 || c > 1) begin
          r = clip48(r / c);
          i = clip48(i / c);
          c = 1;
          acc_re[ch] = r;
          acc_im[ch] = i;
          acc_cnt[ch] = c;
        end
      end else begin
        ar = longint'(t.re);
        ai = longint'(t.im);
        ac = int'(t.cnt);
        if (!loaded) begin
          acc_re[ch] = ar;
          acc_im[ch] = ai;
          acc_cnt[ch] = ac;
          touched[ch] = 1'b1;
        end else if (ac > 0) begin
          if (acc_cnt[ch] > 0) begin
            acc_re[ch] = clip48(acc_re[ch] + ar);
            acc_im[ch] = clip48(acc_im[ch] + ai);
          end else begin
            acc_re[ch] = ar;
            acc_im[ch] = ai;
          end
          acc_cnt[ch] = clip16(acc_cnt[ch] + ac);
        end
        r = acc_re[ch];
        i = acc_im[ch];
        c = acc_cnt[ch];
        if (!t.last) return;
        loaded = 1'b1;
        reason_acc |= t.reason;
        if ((t.reason & m1_mask) != 0) m1_cnt++;
        if ((t.reason & m2_mask) != 0) m2_cnt++;
      end
      e.re = r[SUM_W-1:0];
      e.im = i[SUM_W-1:0];
      e.cnt = c[CNT_W-1:0];
      e.status = !loaded ? STAT_BLANK : ((reason_acc & ~noflag) != 0 ? STAT_FLAG : STAT_OK);
      e.reason = reason_acc;
      e.m1 = m1_cnt;
      e.m2 = m2_cnt;
      due.push_back(e);
    endfunction

    function void check(spec_res_t got);
      spec_res_t e;
      if (due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with nothing outstanding");
        return;
      end
      e = due.pop_front();
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: exp re=%0d im=%0d cnt=%0d st=%0d rsn=%h m1=%0d m2=%0d,",
                    " got re=%0d im=%0d cnt=%0d st=%0d rsn=%h m1=%0d m2=%0d"},
                   e.re, e.im, e.cnt, e.status, e.reason, e.m1, e.m2,
                   got.re, got.im, got.cnt, got.status, got.reason, got.m1, got.m2);
      end
    endfunction
  endclass

  logic                     clk_i, rst_ni;
  logic                     in_valid_i, in_ready_o;
  logic                     req_type_i;
  logic [CH_W-1:0]          channel_i;
  logic signed [VAL_W-1:0]  in_real_i, in_imag_i;
  logic signed [CNT_W-1:0]  in_count_i;
  logic                     frame_last_i;
  logic [WORD_W-1:0]        frame_reason_i;
  logic                     out_valid_o, out_ready_i;
  logic signed [SUM_W-1:0]  out_real_o, out_imag_o;
  logic signed [CNT_W-1:0]  out_count_o;
  logic [1:0]               flag_status_o;
  logic [WORD_W-1:0]        reason_word_o, minor1_total_o, minor2_total_o;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [WORD_W-1:0]        cfg_data_i;

  spectrum_channel_integrator_unit DUT (.*);

  integ_scoreboard sb;
  bit              calm;       // set during the stretch with no idling on either side
  int unsigned     sent;
  int unsigned     live_ch[$]; // channels whose store entry has been written

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run (divider reads plus stalls).
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

  // Receiver back-pressure: roughly one stall cycle in ten outside the calm stretch.
  always @(negedge clk_i)
    out_ready_i <= rst_ni && (calm || ($urandom_range(99) >= 10));

  always @(posedge clk_i) begin
    spec_res_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.re = out_real_o;
      got.im = out_imag_o;
      got.cnt = out_count_o;
      got.status = flag_status_o;
      got.reason = reason_word_o;
      got.m1 = minor1_total_o;
      got.m2 = minor2_total_o;
      sb.check(got);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with
  // valid still high, so back-to-back transactions keep valid asserted.
  task automatic send_txn(input spec_txn_t t);
    if (!calm && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= t.kind;
    channel_i      <= t.chan;
    in_real_i      <= t.re;
    in_imag_i      <= t.im;
    in_count_i     <= t.cnt;
    frame_last_i   <= t.last;
    frame_reason_i <= t.reason;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note(t);
    sent++;
    @(negedge clk_i);
  endtask

  // Wait for every outstanding result, then let any result-less accumulate finish.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.due.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic acc(input int unsigned ch, input logic [31:0] re, input logic [31:0] im,
                     input logic [15:0] cnt, input bit last, input logic [31:0] rsn);
    spec_txn_t t;
    t.kind = REQ_ACC; t.chan = CH_W'(ch); t.re = re; t.im = im; t.cnt = cnt;
    t.last = last; t.reason = rsn;
    if (!sb.touched[ch]) live_ch.push_back(ch);
    send_txn(t);
  endtask

  task automatic rd(input int unsigned ch, input bit last, input logic [31:0] rsn);
    spec_txn_t t;
    t.kind = REQ_READ; t.chan = CH_W'(ch); t.re = $urandom; t.im = $urandom;
    t.cnt = CNT_W'($urandom);
    t.last = last; t.reason = rsn;
    send_txn(t);
  endtask

  function automatic logic [15:0] pick_count();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 16'($urandom_range(1, 8));
    if (p < 70) return 16'($urandom);
    if (p < 80) return 16'd0;
    if (p < 92) return -16'($urandom_range(1, 6));
    return 16'sh7FFF;
  endfunction

  function automatic logic [31:0] pick_reason();
    case ($urandom_range(3))
      0:       return 32'd0;
      2:       return $urandom;
      default: return 32'd1 << $urandom_range(31);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly frame-shaped traffic over written channels, with reads mixed in and
  // the odd stray frame_last on a read.
  task automatic random_burst(input int unsigned n);
    int unsigned stop, ch;
    stop = sent + n;
    while (sent < stop) begin
      calm = (sent >= 900 && sent < 1200);
      ch = live_ch[$urandom_range(live_ch.size() - 1)];
      if ($urandom_range(99) < 20)
        rd(ch, $urandom_range(3) == 0, $urandom);
      else
        acc(ch, pick_value(), pick_value(), pick_count(), $urandom_range(7) == 0,
            pick_reason());
    end
    calm = 1'b0;
  endtask

  initial begin
    int unsigned k, waited;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0; req_type_i = 1'b0; channel_i = '0; in_real_i = '0; in_imag_i = '0;
    in_count_i = '0; frame_last_i = 1'b0; frame_reason_i = '0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_NOFLAG; cfg_data_i = '0;
    calm = 1'b0;
    sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_NOFLAG, 32'h0000_000F);
    write_reg(CFG_MINOR1, 32'h0000_0001);
    write_reg(CFG_MINOR2, 32'h8000_0000);

    // First frame: copied verbatim whatever the count, channels chosen so every
    // channel bit is both set and clear; a read before load reports blanked.
    acc(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'sh7FFF, 1'b0, 32'hFFFF_FFFF);
    acc(1023, 32'h8000_0000, 32'h7FFF_FFFF, 16'sh8000, 1'b0, 32'h0);
    rd(1023, 1'b1, 32'hFFFF_FFFF);
    for (k = 0; k < 10; k++) begin
      acc(1 << k, pick_value(), pick_value(), 16'(k) - 16'd3, 1'b0, 32'h0);
      acc(1023 ^ (1 << k), pick_value(), pick_value(), 16'(k + 2), k == 9,
          32'h8000_0001);
    end
    // After load: add onto positive count, replace non-positive, ignore
    // non-positive incoming, count saturation, reads with various counts.
    acc(1022, 32'h0001_0000, 32'hFFFF_0000, 16'd3, 1'b1, 32'h0000_0010);
    acc(1, 32'h0000_1234, 32'h0000_5678, 16'd2, 1'b1, 32'h0);
    acc(2, 32'h1111_1111, 32'h2222_2222, 16'sh8000, 1'b1, 32'h0);
    acc(0, 32'h7FFF_FFFF, 32'h8000_0000, 16'sh7FFF, 1'b1, 32'h0000_0001);
    rd(0, 1'b0, 32'h0);
    rd(1023, 1'b0, 32'h0);
    rd(8, 1'b0, 32'h0);
    rd(2, 1'b1, 32'hFFFF_FFFF);
    settle();

    // Four settings, extremes among them, each followed by a random burst.
    for (k = 0; k < 4; k++) begin
      case (k)
        0: begin write_reg(CFG_NOFLAG, 32'h0); write_reg(CFG_MINOR1, 32'h0);
                 write_reg(CFG_MINOR2, 32'h0); end
        1: begin write_reg(CFG_NOFLAG, 32'hFFFF_FFFF); write_reg(CFG_MINOR1, 32'hFFFF_FFFF);
                 write_reg(CFG_MINOR2, 32'hFFFF_FFFF); end
        2: begin write_reg(CFG_NOFLAG, $urandom); write_reg(CFG_MINOR1, $urandom);
                 write_reg(CFG_MINOR2, $urandom); end
        default: begin write_reg(CFG_NOFLAG, 32'hFFFF_0000);
                 write_reg(CFG_MINOR1, 32'h0000_FFFF); write_reg(CFG_MINOR2, 32'h0001_0000); end
      endcase
      random_burst(480);
      settle();
    end

    waited = 0;
    while (sb.due.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (100) @(negedge clk_i);
    if (sb.errors == 0 && sb.due.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
